// ----- src/ps2mq_pkg.sv -----
// shared constants and types for the ps2 mouse packet queue
package ps2mq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;

  localparam int BYTE_W   = 8;
  localparam int BUTTON_W = 3;
  localparam int SYNC_BIT = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons;
    logic [BYTE_W-1:0]   x_move;
    logic [BYTE_W-1:0]   y_move;
  } packet_t;

  localparam int ENTRY_W = $bits(packet_t);

  localparam logic IN_KIND_BYTE = 1'b0;
  localparam logic IN_KIND_READ = 1'b1;

endpackage

// ----- src/ps2_mouse_packet_assembler_fifo.sv -----
// ps2 mouse packet framer with a ring queue of decoded packets
//
// input channel: each word is either a mouse byte (in_tuser low) or a read
// request (in_tuser high). mouse bytes are framed into three-byte packets; a
// first byte is taken only with its bit 3 set. a finished packet is decoded
// into buttons, x and negated y and pushed into a ram-based ring queue of
// QUEUE_DEPTH entries; it is dropped when the queue is full.
// output channel: one word per read request. out_tuser high means a packet was
// popped; low means the queue was empty or the buffer was too small, and the
// data is then zero. mouse bytes produce no output word.
// throughput: one input word per cycle unless a held read result stalls the
// input, set by the single ram write port and single ram read port, each used
// at most once per word. a read result is registered by the ram read stage
// and then by the output register before it is presented.
// reset clears framing, pointers and fill count; ram contents are not cleared
// and are only read after being written.
// when out_tready is low, one result waits in the output register and one
// more in the read stage; mouse bytes keep flowing until both are full.
module ps2_mouse_packet_assembler_fifo
  import ps2mq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte[7:0], buffer_fits[8]
  input  logic                   in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // buttons[2:0], x_move[10:3], y_move[18:11]
  output logic                   out_tuser   // has_packet
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] second_r, second_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_has_r, s1_has_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_has_r, out_has_nxt;
  packet_t out_pkt_r, out_pkt_nxt;

  logic              s1_adv, acc, is_read, is_byte, push, pop;
  logic [BYTE_W-1:0] rx_byte;
  logic              fits;
  packet_t           wr_pkt, rd_pkt;

  assign rx_byte = in_tdata[BYTE_W-1:0];
  assign fits    = in_tdata[BYTE_W];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;
  assign is_read   = acc && (in_tuser == IN_KIND_READ);
  assign is_byte   = acc && (in_tuser == IN_KIND_BYTE);
  assign push      = is_byte && (phase_r == PH_THIRD) && (fill_r != CNT_FULL);
  assign pop       = is_read && fits && (fill_r != '0);

  assign wr_pkt.buttons = first_r[BUTTON_W-1:0];
  assign wr_pkt.x_move  = second_r;
  assign wr_pkt.y_move  = BYTE_W'(~rx_byte + 1'b1);

  // framing
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    if (is_byte) begin
      unique case (phase_r)
        PH_FIRST: begin
          first_nxt = rx_byte;
          phase_nxt = rx_byte[SYNC_BIT] ? PH_SECOND : PH_FIRST;
        end
        PH_SECOND: begin
          second_nxt = rx_byte;
          phase_nxt  = PH_THIRD;
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
  end

  // read stage and output register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_has_nxt   = s1_has_r;
    if (is_read) begin
      s1_valid_nxt = 1'b1;
      s1_has_nxt   = pop;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_has_nxt   = out_has_r;
    out_pkt_nxt   = out_pkt_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_has_nxt   = s1_has_r;
      out_pkt_nxt   = s1_has_r ? rd_pkt : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    s1_has_r  <= s1_has_nxt;
    out_has_r <= out_has_nxt;
    out_pkt_r <= out_pkt_nxt;
  end

  ps2mq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr_r),
    .wr_data (wr_pkt),
    .rd_en   (pop),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_pkt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_has_r;
  assign out_tdata  = {(OUT_TDATA_W - ENTRY_W)'(0),
                       out_pkt_r.y_move, out_pkt_r.x_move, out_pkt_r.buttons};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_FULL)
    else $error("fill count above queue depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !pop && fill_nxt == fill_r + 1'b1)
    else $error("push into full queue or alongside a pop");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_pkt_r == '0)
    else $error("empty result carries data");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIRST || phase_r == PH_SECOND || phase_r == PH_THIRD)
    else $error("framing phase left its legal range");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_has_r))
    else $error("stalled read stage lost its result");

endmodule

// ----- src/ps2mq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module ps2mq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
